// ===== rtl/core/spq_pkg.sv =====
// ---------------------------------------------------------------------------
// spq_pkg
// Shared constants, result codes and cell control type for the sorted
// priority queue.
// ---------------------------------------------------------------------------
package spq_pkg;

    localparam int DATA_W        = 32;
    localparam int DEPTH_DEFAULT = 16;
    localparam int STATUS_W      = 2;

    localparam logic OP_INSERT = 1'b0;
    localparam logic OP_DELETE = 1'b1;

    localparam logic [STATUS_W-1:0] STATUS_DONE      = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_OVERFLOW  = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_EMPTY     = 2'd2;
    localparam logic [STATUS_W-1:0] STATUS_NOT_FOUND = 2'd3;

    typedef struct packed {
        logic capture;
        logic apply;
        logic del;
    } spq_ctrl_t;

endpackage

// ===== rtl/core/spq_cell.sv =====
// ---------------------------------------------------------------------------
// spq_cell
// One slot of the sorted row: holds an entry, compares it with the operand
// and shifts toward either neighbor when the row is updated.
// ---------------------------------------------------------------------------
module spq_cell (
    input  logic                      aclk,
    input  spq_pkg::spq_ctrl_t        ctrl,
    input  logic                      valid_in,
    input  logic [spq_pkg::DATA_W-1:0] cmp_value,
    input  logic [spq_pkg::DATA_W-1:0] ins_value,
    input  logic                      left_ge,
    input  logic [spq_pkg::DATA_W-1:0] left_data,
    input  logic [spq_pkg::DATA_W-1:0] right_data,
    output logic [spq_pkg::DATA_W-1:0] data,
    output logic [spq_pkg::DATA_W-1:0] data_next,
    output logic                      ge,
    output logic                      eq
);

    logic [spq_pkg::DATA_W-1:0] data_reg;
    logic                       ge_reg;
    logic                       eq_reg;

    always_comb begin
        data_next = data_reg;
        if (ctrl.apply && ge_reg) begin
            if (ctrl.del) begin
                data_next = right_data;
            end else if (left_ge) begin
                data_next = left_data;
            end else begin
                data_next = ins_value;
            end
        end
    end

    always_ff @(posedge aclk) begin
        data_reg <= data_next;
        if (ctrl.capture) begin
            ge_reg <= !valid_in || ($signed(cmp_value) >= $signed(data_reg));
            eq_reg <= valid_in && (cmp_value == data_reg);
        end
    end

    assign data = data_reg;
    assign ge   = ge_reg;
    assign eq   = eq_reg;

endmodule

// ===== rtl/core/sorted_priority_queue.sv =====
// timing: an accepted transaction is compared in the cells on capture (ST_IDLE), then shifted and its result
// registered in ST_APPLY; no new transaction is accepted until that update is done, and a stalled
// result holds the update
// reset: synchronous active-low aresetn empties the queue and clears the result valid flag;
// entry contents are not cleared, only the entry count
// ---------------------------------------------------------------------------
// sorted_priority_queue
// Descending sorted store built from a row of compare-and-shift cells with
// insert by priority and delete of the first matching entry.
// ---------------------------------------------------------------------------
module sorted_priority_queue #(
    parameter int DEPTH = spq_pkg::DEPTH_DEFAULT
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [spq_pkg::DATA_W-1:0]        s_tdata,   // value
    input  logic                              s_tuser,   // operation
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // status, count, top_value, zero fill
    output logic [((spq_pkg::STATUS_W + $clog2(DEPTH + 1) + spq_pkg::DATA_W + 7) / 8) * 8 - 1:0]
                                              m_tdata
);

    localparam int CNT_W   = $clog2(DEPTH + 1);
    localparam int PAY_W   = spq_pkg::STATUS_W + CNT_W + spq_pkg::DATA_W;
    localparam int TDATA_W = ((PAY_W + 7) / 8) * 8;

    localparam logic ST_IDLE  = 1'b0;
    localparam logic ST_APPLY = 1'b1;

    logic                        state_reg, state_next;
    logic [CNT_W-1:0]            held_reg, held_next;
    logic [spq_pkg::DATA_W-1:0]  value_reg;
    logic                        del_reg;
    logic                        m_tvalid_reg, m_tvalid_next;
    logic [spq_pkg::STATUS_W-1:0] m_status_reg, status;
    logic [CNT_W-1:0]            m_count_reg;
    logic [spq_pkg::DATA_W-1:0]  m_top_reg;

    logic [spq_pkg::DATA_W-1:0]  data_vec [DEPTH];
    logic [spq_pkg::DATA_W-1:0]  next_vec [DEPTH];
    logic [DEPTH-1:0]            ge_vec;
    logic [DEPTH-1:0]            eq_vec;

    spq_pkg::spq_ctrl_t          ctrl;
    logic                        accept, fire, found, full, empty;

    assign s_tready = (state_reg == ST_IDLE);
    assign accept   = s_tvalid && s_tready;
    assign fire     = (state_reg == ST_APPLY) && (!m_tvalid_reg || m_tready);
    assign found    = |eq_vec;
    assign full     = (held_reg == CNT_W'(DEPTH));
    assign empty    = (held_reg == '0);

    always_comb begin
        status = spq_pkg::STATUS_DONE;
        if (del_reg == spq_pkg::OP_DELETE) begin
            if (empty) begin
                status = spq_pkg::STATUS_EMPTY;
            end else if (!found) begin
                status = spq_pkg::STATUS_NOT_FOUND;
            end
        end else if (full) begin
            status = spq_pkg::STATUS_OVERFLOW;
        end
    end

    always_comb begin
        ctrl.capture = accept;
        ctrl.apply   = fire && (status == spq_pkg::STATUS_DONE);
        ctrl.del     = (del_reg == spq_pkg::OP_DELETE);
    end

    always_comb begin
        held_next = held_reg;
        if (ctrl.apply) begin
            held_next = ctrl.del ? held_reg - CNT_W'(1) : held_reg + CNT_W'(1);
        end
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    state_next = ST_APPLY;
                end
            end
            ST_APPLY: begin
                if (fire) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        m_tvalid_next = m_tvalid_reg;
        if (fire) begin
            m_tvalid_next = 1'b1;
        end else if (m_tready) begin
            m_tvalid_next = 1'b0;
        end
    end

    for (genvar i = 0; i < DEPTH; i++) begin : g_cell
        logic                       left_ge;
        logic [spq_pkg::DATA_W-1:0] left_data;
        logic [spq_pkg::DATA_W-1:0] right_data;

        if (i == 0) begin : g_head
            assign left_ge   = 1'b0;
            assign left_data = value_reg;
        end else begin : g_body
            assign left_ge   = ge_vec[i-1];
            assign left_data = data_vec[i-1];
        end

        if (i == DEPTH - 1) begin : g_tail
            assign right_data = data_vec[i];
        end else begin : g_inner
            assign right_data = data_vec[i+1];
        end

        spq_cell u_cell (
            .aclk       (aclk),
            .ctrl       (ctrl),
            .valid_in   (CNT_W'(i) < held_reg),
            .cmp_value  (s_tdata),
            .ins_value  (value_reg),
            .left_ge    (left_ge),
            .left_data  (left_data),
            .right_data (right_data),
            .data       (data_vec[i]),
            .data_next  (next_vec[i]),
            .ge         (ge_vec[i]),
            .eq         (eq_vec[i])
        );
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            held_reg     <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            held_reg     <= held_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            value_reg <= s_tdata;
            del_reg   <= s_tuser;
        end
        if (fire) begin
            m_status_reg <= status;
            m_count_reg  <= held_next;
            m_top_reg    <= (held_next == '0) ? '0 : next_vec[0];
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = TDATA_W'({m_top_reg, m_count_reg, m_status_reg});

`ifndef SYNTHESIS
    a_held_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        held_reg <= CNT_W'(DEPTH))
        else $error("entry count exceeds depth");

    a_accept_to_apply: assert property (@(posedge aclk) disable iff (!aresetn)
        accept |=> (state_reg == ST_APPLY))
        else $error("accepted transaction did not reach update cycle");

    a_empty_top_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid_reg && (m_count_reg == '0)) |-> (m_top_reg == '0))
        else $error("nonzero top value on empty queue");

    a_overflow_full: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid_reg && (m_status_reg == spq_pkg::STATUS_OVERFLOW))
            |-> (m_count_reg == CNT_W'(DEPTH)))
        else $error("overflow reported while not full");

    a_fire_result: assert property (@(posedge aclk) disable iff (!aresetn)
        fire |=> m_tvalid_reg)
        else $error("update cycle produced no result");
`endif

endmodule

// ===== tb/sv/spq_checker.sv =====
// ---------------------------------------------------------------------------
// spq_checker
// Watches both stream channels of the sorted priority queue. Each accepted
// input transaction is run through a private sorted store to get the
// expected status, count and top value; each accepted result is compared
// field by field with the oldest pending expectation.
// ---------------------------------------------------------------------------
module spq_checker #(
    parameter int DEPTH = spq_pkg::DEPTH_DEFAULT,
    parameter int CNT_W = $clog2(DEPTH + 1),
    parameter int TD_W  = ((spq_pkg::STATUS_W + CNT_W + spq_pkg::DATA_W + 7) / 8) * 8
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       s_tvalid,
    input  logic                       s_tready,
    input  logic [spq_pkg::DATA_W-1:0] s_tdata,   // value
    input  logic                       s_tuser,   // operation
    input  logic                       m_tvalid,
    input  logic                       m_tready,
    input  logic [TD_W-1:0]            m_tdata,   // status, count, top_value, zero fill
    output int                         err_count,
    output int                         outstanding
);
    timeunit 1ns;
    timeprecision 1ps;

    import spq_pkg::*;

    typedef struct packed {
        logic [STATUS_W-1:0]     status;
        logic [CNT_W-1:0]        count;
        logic signed [DATA_W-1:0] top;
    } queue_result_t;

    logic signed [DATA_W-1:0] sorted_vals [DEPTH];
    int                       fill;
    queue_result_t            pending_q [$];

    function automatic queue_result_t predict_result(input logic op,
                                                     input logic signed [DATA_W-1:0] val);
        queue_result_t r;
        int            pos;
        int            k;
        r.status = STATUS_DONE;
        pos = fill;
        if (op == OP_INSERT) begin
            if (fill >= DEPTH) begin
                r.status = STATUS_OVERFLOW;
            end else begin
                for (k = 0; k < fill; k++)
                    if (pos == fill && val >= sorted_vals[k]) pos = k;
                for (k = fill; k > pos; k--)
                    sorted_vals[k] = sorted_vals[k-1];
                sorted_vals[pos] = val;
                fill++;
            end
        end else if (fill == 0) begin
            r.status = STATUS_EMPTY;
        end else begin
            for (k = 0; k < fill; k++)
                if (pos == fill && sorted_vals[k] == val) pos = k;
            if (pos == fill) begin
                r.status = STATUS_NOT_FOUND;
            end else begin
                for (k = pos; k + 1 < fill; k++)
                    sorted_vals[k] = sorted_vals[k+1];
                fill--;
            end
        end
        r.count = CNT_W'(fill);
        r.top   = (fill > 0) ? sorted_vals[0] : '0;
        return r;
    endfunction

    task automatic report_mismatch(input string field, input logic [DATA_W-1:0] got,
                                   input logic [DATA_W-1:0] want);
        $display("spq_checker: %0t %s mismatch, got %0h expected %0h", $time, field, got, want);
        err_count++;
    endtask

    always @(posedge aclk) begin
        queue_result_t want;
        queue_result_t got;
        if (!aresetn) begin
            fill = 0;
            pending_q.delete();
            err_count = 0;
        end else begin
            if (m_tvalid && m_tready) begin
                got.status = m_tdata[STATUS_W-1:0];
                got.count  = m_tdata[STATUS_W +: CNT_W];
                got.top    = m_tdata[STATUS_W + CNT_W +: DATA_W];
                if (pending_q.size() == 0) begin
                    report_mismatch("result with nothing pending", got.top, '0);
                end else begin
                    want = pending_q.pop_front();
                    if (got.status != want.status)
                        report_mismatch("status", DATA_W'(got.status), DATA_W'(want.status));
                    if (got.count != want.count)
                        report_mismatch("count", DATA_W'(got.count), DATA_W'(want.count));
                    if (got.top != want.top)
                        report_mismatch("top_value", got.top, want.top);
                end
            end
            if (s_tvalid && s_tready)
                pending_q.push_back(predict_result(s_tuser, s_tdata));
        end
        outstanding <= pending_q.size();
    end

endmodule

// ===== tb/sv/tb_top.sv =====
// ---------------------------------------------------------------------------
// tb_top
// Stimulus and verdict for the sorted priority queue: a directed run over
// the value extremes, ties, empty, missing and full cases, then random
// insert and delete transactions drawn mostly from a small value pool so
// that deletes hit stored entries, with random idling on both channels and
// one long result stall.
// ---------------------------------------------------------------------------
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import spq_pkg::*;

    localparam int DEPTH  = DEPTH_DEFAULT;
    localparam int CNT_W  = $clog2(DEPTH + 1);
    localparam int TD_W   = ((STATUS_W + CNT_W + DATA_W + 7) / 8) * 8;
    localparam int N_RAND = 1950;

    logic              aclk;
    logic              aresetn;
    logic              s_tvalid;
    logic              s_tready;
    logic [DATA_W-1:0] s_tdata;   // value
    logic              s_tuser;   // operation
    logic              m_tvalid;
    logic              m_tready;
    logic [TD_W-1:0]   m_tdata;   // status, count, top_value, zero fill

    int   err_count;
    int   outstanding;
    int   n_sent;
    logic quiet;

    sorted_priority_queue #(.DEPTH(DEPTH)) dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .s_tuser (s_tuser),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata)
    );

    spq_checker #(.DEPTH(DEPTH)) chk (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .err_count  (err_count),
        .outstanding(outstanding)
    );

    initial aclk = 1'b0;
    always #5 aclk = ~aclk;

    task automatic send_item(input logic op, input logic [DATA_W-1:0] val);
        while (!quiet && $urandom_range(0, 99) < 23) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= val;
        do @(posedge aclk); while (!s_tready);
        @(negedge aclk);
        n_sent++;
    endtask

    // receiver: random stalls, and one long hold-off that also stalls the sender
    initial begin
        logic held_off;
        held_off = 1'b0;
        m_tready = 1'b0;
        forever begin
            @(negedge aclk);
            if (!held_off && n_sent >= 1300) begin
                m_tready <= 1'b0;
                repeat (300) @(negedge aclk);
                held_off = 1'b1;
            end else begin
                m_tready <= quiet || ($urandom_range(0, 99) >= 23);
            end
        end
    end

    initial begin
        #2ms;
        $display("tb_top: done, errors");
        $finish;
    end

    initial begin
        logic [DATA_W-1:0] pool [10];
        int                ins_pct;
        int                k;
        logic              op;
        logic [DATA_W-1:0] val;

        aresetn  = 1'b0;
        s_tvalid = 1'b0;
        s_tuser  = OP_INSERT;
        s_tdata  = '0;
        n_sent   = 0;
        quiet    = 1'b0;
        ins_pct  = 50;
        repeat (8) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // directed: extremes, ties, empty, missing, full
        send_item(OP_DELETE, 32'd7);
        send_item(OP_INSERT, 32'h7FFF_FFFF);
        send_item(OP_INSERT, 32'h8000_0000);
        send_item(OP_INSERT, 32'h0000_0000);
        send_item(OP_INSERT, 32'h0000_0000);
        send_item(OP_INSERT, 32'hFFFF_FFFF);
        send_item(OP_DELETE, 32'd5);
        send_item(OP_DELETE, 32'h0000_0000);
        send_item(OP_DELETE, 32'h8000_0000);
        for (k = 0; k < DEPTH - 3; k++)
            send_item(OP_INSERT, DATA_W'(k * 977 - 6000));
        send_item(OP_INSERT, 32'h7FFF_FFFF);
        send_item(OP_DELETE, 32'h7FFF_FFFF);
        send_item(OP_DELETE, 32'hFFFF_FFFF);

        pool[0] = 32'h7FFF_FFFF;
        pool[1] = 32'h8000_0000;
        pool[2] = 32'h0000_0000;
        pool[3] = 32'hFFFF_FFFF;
        for (k = 4; k < 10; k++)
            pool[k] = (k < 7) ? DATA_W'($urandom_range(0, 40)) - 20 : $urandom;

        for (k = 0; k < N_RAND; k++) begin
            if (k % 150 == 0)
                ins_pct = $urandom_range(20, 85);
            quiet = (k >= 600 && k < 900);
            op  = ($urandom_range(0, 99) < ins_pct) ? OP_INSERT : OP_DELETE;
            val = ($urandom_range(0, 99) < 80) ? pool[$urandom_range(0, 9)] : $urandom;
            send_item(op, val);
        end
        s_tvalid <= 1'b0;

        while (outstanding != 0) @(posedge aclk);
        repeat (10) @(posedge aclk);
        if (err_count == 0 && outstanding == 0)
            $display("tb_top: done, clean");
        else
            $display("tb_top: done, errors");
        $finish;
    end

endmodule
